>>> hw/rtl/dsg_pkg.sv
// ----------------------------------------------------------------------------
// dsg_pkg
// Shared types and constants for the damped sine generator: register map,
// configuration bundle, envelope and sine polynomial constants.
// ----------------------------------------------------------------------------
package dsg_pkg;

  // Default parameter values for the top level
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Phase accumulator and envelope
  localparam int PHASE_W = 32;
  localparam int ENV_W   = 17;
  localparam int AMP_W   = 15;
  localparam int OUT_W   = 16;
  localparam logic [ENV_W-1:0] ENV_ONE = 17'h1_0000;
  localparam logic [ENV_W-1:0] ENV_MAX = 17'h1_FFFF;

  // Sine polynomial constants, Q30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] SC1     = 31'd1686629713;
  localparam logic [29:0] SC3     = 30'd693598668;
  localparam logic [26:0] SC5     = 27'd85569306;
  localparam logic [22:0] SC7     = 23'd4858527;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_START_PHASE  = 3'd1,
    REG_AMPLITUDE    = 3'd2,
    REG_DC_OFFSET    = 3'd3,
    REG_DECAY_FACTOR = 3'd4
  } cfg_reg_t;

  // Configuration bundle
  typedef struct packed {
    logic [PHASE_W-1:0]      phase_step;
    logic [PHASE_W-1:0]      start_phase;
    logic [AMP_W-1:0]        amplitude;
    logic signed [OUT_W-1:0] dc_offset;
    logic [ENV_W-1:0]        decay_factor;
  } cfg_t;

endpackage

>>> hw/rtl/dsg_front.sv
// ----------------------------------------------------------------------------
// dsg_front
// Accepts tick items, applies restart, advances the phase accumulator and
// the decay envelope, and pushes the table index and envelope to the queue.
// ----------------------------------------------------------------------------
module dsg_front #(
  parameter int IDX_W = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsg_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_restart,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [IDX_W+dsg_pkg::ENV_W-1:0] q_data
);

  logic [dsg_pkg::PHASE_W-1:0] phase_acc_r, phase_acc_nxt;
  logic [dsg_pkg::ENV_W-1:0]   env_r, env_nxt;
  logic [dsg_pkg::PHASE_W-1:0] cur_phase;
  logic [dsg_pkg::ENV_W-1:0]   cur_env;
  logic [2*dsg_pkg::ENV_W-1:0] env_prod;
  logic                        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Restart reloads phase and unit envelope before this sample
  assign cur_phase = in_restart ? cfg.start_phase : phase_acc_r;
  assign cur_env   = in_restart ? dsg_pkg::ENV_ONE : env_r;

  // Envelope decay: truncating Q1.16 multiply, saturating
  assign env_prod = cur_env * cfg.decay_factor;

  always_comb begin
    phase_acc_nxt = phase_acc_r;
    env_nxt       = env_r;
    if (accept) begin
      phase_acc_nxt = cur_phase + cfg.phase_step;
      env_nxt       = env_prod[2*dsg_pkg::ENV_W-1] ? dsg_pkg::ENV_MAX
                                                   : env_prod[2*dsg_pkg::ENV_W-2:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      env_r       <= dsg_pkg::ENV_ONE;
    end else begin
      phase_acc_r <= phase_acc_nxt;
      env_r       <= env_nxt;
    end
  end

  // Item to the back end: table index and the envelope of this sample
  assign q_push = accept;
  assign q_data = {cur_phase[dsg_pkg::PHASE_W-1 -: IDX_W], cur_env};

endmodule

>>> hw/rtl/dsg_queue.sv
// ----------------------------------------------------------------------------
// dsg_queue
// Short FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module dsg_queue #(
  parameter int DATA_W = 27
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              full,
  output logic              not_empty
);

  localparam int DEPTH = dsg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/dsg_back.sv
// ----------------------------------------------------------------------------
// dsg_back
// Sample pipeline: sine magnitude by a Q30 odd polynomial in Horner form,
// amplitude and envelope scaling, offset and saturation. Stalls as a whole
// when the output register is held.
// ----------------------------------------------------------------------------
module dsg_back #(
  parameter int IDX_W       = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dsg_pkg::cfg_t                   cfg,
  input  logic                            q_not_empty,
  input  logic [IDX_W+dsg_pkg::ENV_W-1:0] q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dsg_pkg::OUT_W-1:0]       out_sample
);

  localparam int ENV_W   = dsg_pkg::ENV_W;
  localparam int SUM_W   = (SAMPLE_BITS + 1 > 19) ? SAMPLE_BITS + 1 : 19;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic en;
  logic [7:0] vld_r;

  // Stage registers
  logic [30:0] s1_z_r, s2_z_r, s3_z_r, s4_z_r, s5_z_r;
  logic        s1_neg_r, s2_neg_r, s3_neg_r, s4_neg_r, s5_neg_r, s6_neg_r, s7_neg_r;
  logic        s8_neg_r;
  logic [ENV_W-1:0] s1_env_r;
  logic [30:0] s2_z2_r, s3_z2_r, s4_z2_r;
  logic [31:0] s2_p_r, s3_p_r, s4_p_r, s5_p_r, s6_p_r, s7_p_r;
  logic [26:0] s3_t_r;
  logic [29:0] s4_t_r;
  logic [30:0] s5_t_r;
  logic [30:0] s6_s_r;
  logic [14:0] s7_m_r;
  logic [46:0] s8_prod_r;
  logic                      out_valid_r;
  logic [dsg_pkg::OUT_W-1:0] out_sample_r;

  // Combinational stage results
  logic [31:0] ang;
  logic [29:0] rem;
  logic [30:0] s1_z_nxt;
  logic [61:0] zz;
  logic [31:0] p_nxt;
  logic [53:0] m3;
  logic [26:0] s3_t_nxt;
  logic [57:0] m4;
  logic [29:0] s4_t_nxt;
  logic [60:0] m5;
  logic [30:0] s5_t_nxt;
  logic [61:0] m6;
  logic [30:0] s6_s_nxt;
  logic [31:0] rs;
  logic [14:0] s7_m_nxt;
  logic [46:0] s8_prod_nxt;
  logic [47:0] rnd;
  logic signed [18:0] v_s, v_signed, sum;
  logic signed [SUM_W-1:0] sum_ext, sat;

  // Whole pipeline advances unless the output register is held
  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_not_empty;

  // Stage 1: table angle, quadrant fold
  assign ang      = {q_data[IDX_W+ENV_W-1:ENV_W], {(dsg_pkg::PHASE_W-IDX_W){1'b0}}};
  assign rem      = ang[29:0];
  assign s1_z_nxt = ang[30] ? (dsg_pkg::Q30_ONE - {1'b0, rem}) : {1'b0, rem};

  // Stage 2: z squared; amplitude times envelope
  assign zz    = s1_z_r * s1_z_r;
  assign p_nxt = 32'(cfg.amplitude) * 32'(s1_env_r);

  // Stages 3 to 5: Horner steps
  assign m3       = s2_z2_r * dsg_pkg::SC7;
  assign s3_t_nxt = dsg_pkg::SC5 - m3[53:30];
  assign m4       = s3_z2_r * s3_t_r;
  assign s4_t_nxt = dsg_pkg::SC3 - m4[57:30];
  assign m5       = s4_z2_r * s4_t_r;
  assign s5_t_nxt = dsg_pkg::SC1 - m5[60:30];

  // Stage 6: final multiply by z, clamp to one
  assign m6       = s5_z_r * s5_t_r;
  assign s6_s_nxt = (m6[61:30] > 32'(dsg_pkg::Q30_ONE)) ? dsg_pkg::Q30_ONE : m6[60:30];

  // Stage 7: round to Q0.15 magnitude
  assign rs       = {1'b0, s6_s_r} + 32'd16384;
  assign s7_m_nxt = rs[30] ? 15'h7FFF : rs[29:15];

  // Stage 8: scale by amplitude and envelope
  assign s8_prod_nxt = s7_p_r * s7_m_r;

  // Output: round, apply sign, add offset, saturate
  assign rnd      = {1'b0, s8_prod_r} + 48'h0000_4000_0000;
  assign v_s      = {2'b00, rnd[47:31]};
  assign v_signed = s8_neg_r ? -v_s : v_s;
  assign sum      = 19'(cfg.dc_offset) + v_signed;
  assign sum_ext  = SUM_W'(sum);

  always_comb begin
    if (sum_ext > SAT_HI) begin
      sat = SAT_HI;
    end else if (sum_ext < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = sum_ext;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[6:0], q_not_empty};
      out_valid_r <= vld_r[7];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_z_r       <= s1_z_nxt;
      s1_neg_r     <= ang[31];
      s1_env_r     <= q_data[ENV_W-1:0];
      s2_z2_r      <= zz[60:30];
      s2_z_r       <= s1_z_r;
      s2_neg_r     <= s1_neg_r;
      s2_p_r       <= p_nxt;
      s3_t_r       <= s3_t_nxt;
      s3_z2_r      <= s2_z2_r;
      s3_z_r       <= s2_z_r;
      s3_neg_r     <= s2_neg_r;
      s3_p_r       <= s2_p_r;
      s4_t_r       <= s4_t_nxt;
      s4_z2_r      <= s3_z2_r;
      s4_z_r       <= s3_z_r;
      s4_neg_r     <= s3_neg_r;
      s4_p_r       <= s3_p_r;
      s5_t_r       <= s5_t_nxt;
      s5_z_r       <= s4_z_r;
      s5_neg_r     <= s4_neg_r;
      s5_p_r       <= s4_p_r;
      s6_s_r       <= s6_s_nxt;
      s6_neg_r     <= s5_neg_r;
      s6_p_r       <= s5_p_r;
      s7_m_r       <= s7_m_nxt;
      s7_neg_r     <= s6_neg_r;
      s7_p_r       <= s6_p_r;
      s8_prod_r    <= s8_prod_nxt;
      s8_neg_r     <= s7_neg_r;
      out_sample_r <= sat[dsg_pkg::OUT_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

>>> hw/rtl/damped_sine_generator.sv
// ----------------------------------------------------------------------------
// damped_sine_generator
// Throughput: one item per cycle while the queue has room and the output is
// not held; the front advances phase and envelope on each accepted item, and
// the back is a fully pipelined nine-stage sample datapath.
// Reset: registers take their documented defaults, phase 0, envelope 1.0,
// queue and pipeline empty.
// ----------------------------------------------------------------------------
module damped_sine_generator #(
  parameter int TABLE_DEPTH = dsg_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = dsg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [dsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_restart,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dsg_pkg::OUT_W-1:0] out_sample
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int DATA_W = IDX_W + dsg_pkg::ENV_W;

  dsg_pkg::cfg_t cfg_r, cfg_nxt;

  logic              q_push, q_pop, q_full, q_not_empty;
  logic [DATA_W-1:0] q_wdata, q_rdata;
  logic [dsg_pkg::OUT_W-1:0] sample;

  // Configuration registers; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (dsg_pkg::cfg_reg_t'(cfg_index))
        dsg_pkg::REG_PHASE_STEP:   cfg_nxt.phase_step   = cfg_data;
        dsg_pkg::REG_START_PHASE:  cfg_nxt.start_phase  = cfg_data;
        dsg_pkg::REG_AMPLITUDE:    cfg_nxt.amplitude    = cfg_data[dsg_pkg::AMP_W-1:0];
        dsg_pkg::REG_DC_OFFSET:    cfg_nxt.dc_offset    = cfg_data[dsg_pkg::OUT_W-1:0];
        dsg_pkg::REG_DECAY_FACTOR: cfg_nxt.decay_factor = cfg_data[dsg_pkg::ENV_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step   <= '0;
      cfg_r.start_phase  <= '0;
      cfg_r.amplitude    <= 15'h7FFF;
      cfg_r.dc_offset    <= '0;
      cfg_r.decay_factor <= dsg_pkg::ENV_ONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accept and advance generator state
  dsg_front #(
    .IDX_W (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // Decoupling queue
  dsg_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back: sample pipeline
  dsg_back #(
    .IDX_W       (IDX_W),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (sample)
  );

  assign out_sample = sample;

endmodule
